// ===== rtl/core/smcp_pkg.sv =====
`timescale 1ns / 1ps

package smcp_pkg;

    // Field widths of the request and result words
    localparam int OP_W     = 2;
    localparam int ADDR_W   = 16;
    localparam int SHADOW_W = 8;
    localparam int ERR_W    = 2;

    // Request opcodes
    localparam logic [OP_W-1:0] OP_CHECK    = 2'd0;
    localparam logic [OP_W-1:0] OP_POISON   = 2'd1;
    localparam logic [OP_W-1:0] OP_UNPOISON = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_OK             = 2'd0;
    localparam logic [ERR_W-1:0] ERR_POISON_END     = 2'd1;
    localparam logic [ERR_W-1:0] ERR_UNPOISON_START = 2'd2;
    localparam logic [ERR_W-1:0] ERR_PAST_STORE     = 2'd3;

    // Work the engine does on the shadow store
    localparam logic [1:0] ACT_NONE     = 2'd0;
    localparam logic [1:0] ACT_CHECK    = 2'd1;
    localparam logic [1:0] ACT_POISON   = 2'd2;
    localparam logic [1:0] ACT_UNPOISON = 2'd3;

    // Decoded request
    typedef struct packed {
        logic [1:0]          act;
        logic [ERR_W-1:0]    err;
        logic                start_part;  // start not on a granule boundary
        logic                end_part;    // end not on a granule boundary
        logic                one_gran;    // unaligned start, end inside same granule
        logic [SHADOW_W-1:0] start_off;
        logic [SHADOW_W-1:0] end_off;
    } smcp_req_t;

    // Result word
    typedef struct packed {
        logic             is_poisoned;
        logic [ERR_W-1:0] error_code;
    } smcp_res_t;

endpackage

// ===== rtl/core/smcp_ram.sv =====
`timescale 1ns / 1ps

module smcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/smcp_req_dec.sv =====
`timescale 1ns / 1ps

module smcp_req_dec #(
    parameter int ADDR_BITS     = 16,
    parameter int GRANULE_SHIFT = 3
) (
    input  logic [smcp_pkg::OP_W-1:0]   opcode,
    input  logic [smcp_pkg::ADDR_W-1:0] region_start,
    input  logic [smcp_pkg::ADDR_W-1:0] region_length,
    output smcp_pkg::smcp_req_t         req,
    output logic [ADDR_BITS-GRANULE_SHIFT-1:0] first_idx,
    output logic [ADDR_BITS-GRANULE_SHIFT-1:0] last_idx
);

    localparam int GW = ADDR_BITS - GRANULE_SHIFT;
    localparam int EW = smcp_pkg::ADDR_W + 1;
    localparam int XW = (ADDR_BITS > EW) ? ADDR_BITS : EW;
    localparam int SW = smcp_pkg::SHADOW_W;
    localparam logic [EW-1:0] GMASK     = EW'((1 << GRANULE_SHIFT) - 1);
    localparam logic [32:0]   STORE_END = 33'd1 << ADDR_BITS;

    logic [EW-1:0] start_ext;
    logic [EW-1:0] end_addr;
    logic [EW-1:0] last_byte;
    logic [EW-1:0] start_off_w;
    logic [EW-1:0] end_off_w;
    logic          past;
    logic          start_part;
    logic          end_part;

    // Region bounds and granule offsets
    assign start_ext   = {1'b0, region_start};
    assign end_addr    = start_ext + {1'b0, region_length};
    assign last_byte   = end_addr - EW'(1);
    assign start_off_w = start_ext & GMASK;
    assign end_off_w   = end_addr & GMASK;
    assign start_part  = |start_off_w;
    assign end_part    = |end_off_w;
    assign past        = {16'd0, end_addr} > STORE_END;

    assign first_idx = GW'(XW'(start_ext) >> GRANULE_SHIFT);
    assign last_idx  = GW'(XW'(last_byte) >> GRANULE_SHIFT);

    // Request classification
    always_comb
    begin
        req            = '0;
        req.start_part = start_part;
        req.end_part   = end_part;
        req.one_gran   = start_part &&
                         ((end_addr >> GRANULE_SHIFT) == (start_ext >> GRANULE_SHIFT));
        req.start_off  = SW'(start_off_w);
        req.end_off    = SW'(end_off_w);
        req.act        = smcp_pkg::ACT_NONE;
        req.err        = smcp_pkg::ERR_OK;
        if (region_length == '0)
        begin
            req.act = smcp_pkg::ACT_NONE;
        end
        else if (past && (opcode != smcp_pkg::OP_UNUSED))
        begin
            req.err = smcp_pkg::ERR_PAST_STORE;
        end
        else
        begin
            unique case (opcode)
                smcp_pkg::OP_CHECK:
                begin
                    req.act = smcp_pkg::ACT_CHECK;
                end
                smcp_pkg::OP_POISON:
                begin
                    if (end_part)
                    begin
                        req.err = smcp_pkg::ERR_POISON_END;
                    end
                    else
                    begin
                        req.act = smcp_pkg::ACT_POISON;
                    end
                end
                smcp_pkg::OP_UNPOISON:
                begin
                    if (start_part)
                    begin
                        req.err = smcp_pkg::ERR_UNPOISON_START;
                    end
                    else
                    begin
                        req.act = smcp_pkg::ACT_UNPOISON;
                    end
                end
                default:
                begin
                    req.act = smcp_pkg::ACT_NONE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/smcp_engine.sv =====
`timescale 1ns / 1ps

module smcp_engine #(
    parameter int ADDR_BITS     = 16,
    parameter int GRANULE_SHIFT = 3
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [smcp_pkg::OP_W-1:0]          opcode,
    input  logic [smcp_pkg::ADDR_W-1:0]        region_start,
    input  logic [smcp_pkg::ADDR_W-1:0]        region_length,
    input  logic signed [smcp_pkg::SHADOW_W-1:0] poison_value,
    output logic                               res_valid,
    input  logic                               res_ready,
    output smcp_pkg::smcp_res_t                res
);

    localparam int GW    = ADDR_BITS - GRANULE_SHIFT;
    localparam int DEPTH = 2 ** GW;
    localparam int SW    = smcp_pkg::SHADOW_W;
    localparam logic [GW-1:0] IDX_LAST = GW'(DEPTH - 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    smcp_pkg::smcp_req_t dec_req;
    logic [GW-1:0]       dec_first;
    logic [GW-1:0]       dec_last;

    logic [2:0]          state_reg, state_next;
    smcp_pkg::smcp_req_t req_reg, req_next;
    logic [GW-1:0]       cur_reg, cur_next;
    logic [GW-1:0]       first_reg, first_next;
    logic [GW-1:0]       last_reg, last_next;
    logic [SW-1:0]       val_reg, val_next;
    logic                hit_reg, hit_next;
    logic                rdv_reg, rdv_next;
    logic                rdf_reg, rdf_next;
    logic                rdl_reg, rdl_next;

    logic                ram_we;
    logic [GW-1:0]       ram_addr;
    logic [SW-1:0]       ram_wdata;
    logic [SW-1:0]       ram_rdata;

    logic signed [SW-1:0] shadow_k;
    logic                 k_nz;
    logic                 off_gt;
    logic                 gran_hit;

    smcp_req_dec #(
        .ADDR_BITS     (ADDR_BITS),
        .GRANULE_SHIFT (GRANULE_SHIFT)
    ) u_dec (
        .opcode        (opcode),
        .region_start  (region_start),
        .region_length (region_length),
        .req           (dec_req),
        .first_idx     (dec_first),
        .last_idx      (dec_last)
    );

    smcp_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_shadow (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Poison test on the shadow byte read last cycle
    assign shadow_k = signed'(ram_rdata);
    assign k_nz     = shadow_k != '0;
    assign off_gt   = signed'(req_reg.end_off) > shadow_k;

    always_comb
    begin
        if (rdf_reg && req_reg.start_part)
        begin
            gran_hit = req_reg.one_gran ? (k_nz && off_gt) : k_nz;
        end
        else if (rdl_reg && req_reg.end_part)
        begin
            gran_hit = k_nz && off_gt;
        end
        else
        begin
            gran_hit = k_nz;
        end
    end

    // Sequencer: clear sweep, then one granule per cycle per request
    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        cur_next   = cur_reg;
        first_next = first_reg;
        last_next  = last_reg;
        val_next   = val_reg;
        hit_next   = hit_reg | (rdv_reg & gran_hit);
        rdv_next   = 1'b0;
        rdf_next   = 1'b0;
        rdl_next   = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = cur_reg;
        ram_wdata  = '0;
        in_ready   = 1'b0;
        res_valid  = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we   = 1'b1;
                cur_next = cur_reg + GW'(1);
                if (cur_reg == IDX_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    req_next   = dec_req;
                    first_next = dec_first;
                    last_next  = dec_last;
                    cur_next   = dec_first;
                    val_next   = poison_value;
                    hit_next   = 1'b0;
                    state_next = (dec_req.act == smcp_pkg::ACT_NONE) ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN:
            begin
                case (req_reg.act)
                    smcp_pkg::ACT_CHECK:
                    begin
                        rdv_next = 1'b1;
                        rdf_next = cur_reg == first_reg;
                        rdl_next = cur_reg == last_reg;
                    end
                    smcp_pkg::ACT_POISON:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = ((cur_reg == first_reg) && req_reg.start_part)
                                    ? req_reg.start_off : val_reg;
                    end
                    smcp_pkg::ACT_UNPOISON:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = (cur_reg == last_reg) ? req_reg.end_off : '0;
                    end
                    default:
                    begin
                        ram_we = 1'b0;
                    end
                endcase
                if (cur_reg == last_reg)
                begin
                    state_next = (req_reg.act == smcp_pkg::ACT_CHECK) ? ST_DRAIN : ST_DONE;
                end
                else
                begin
                    cur_next = cur_reg + GW'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cur_reg   <= '0;
            hit_reg   <= 1'b0;
            rdv_reg   <= 1'b0;
            req_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            hit_reg   <= hit_next;
            rdv_reg   <= rdv_next;
            req_reg   <= req_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        last_reg  <= last_next;
        val_reg   <= val_next;
        rdf_reg   <= rdf_next;
        rdl_reg   <= rdl_next;
    end

    assign res.is_poisoned = hit_reg;
    assign res.error_code  = req_reg.err;

endmodule

// ===== rtl/core/shadow_memory_poison_checker_core.sv =====
`timescale 1ns / 1ps

// Shadow memory poison checker: one signed shadow byte per granule of the
// covered address space, kept in a single-port RAM.
// Input channel s_axis: one request word per transfer; tuser carries the
// opcode (check, poison, unpoison), tdata the region and the poison code.
// Output channel m_axis: exactly one result word per request, in order.
// From acceptance to the result in the output register: a rejected or empty
// request goes straight to its result; poison and unpoison write each granule
// of the region in turn; a check reads each granule in turn, then drains the
// last read. The RAM port handles one shadow byte per cycle, which sets the
// rate; one request is in work at a time and the next is taken in the cycle
// after its result has moved into the output register.
// After reset the RAM is swept to zero, one granule per cycle, over all
// 2^(ADDR_BITS-GRANULE_SHIFT) granules (8192 granules at the defaults);
// s_axis_tready stays low meanwhile.
// When m_axis_tready is low, one result waits in the output register, the
// engine can finish one more request and then holds until the register frees.

module shadow_memory_poison_checker_core #(
    parameter int ADDR_BITS     = 16,
    parameter int GRANULE_SHIFT = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // region_start, region_length, poison_value
    input  logic [1:0]  s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // is_poisoned, error_code, zero pad
);

    logic                res_valid;
    logic                res_ready;
    smcp_pkg::smcp_res_t res;

    logic                out_valid_reg, out_valid_next;
    smcp_pkg::smcp_res_t out_data_reg, out_data_next;

    smcp_engine #(
        .ADDR_BITS     (ADDR_BITS),
        .GRANULE_SHIFT (GRANULE_SHIFT)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .opcode        (s_axis_tuser),
        .region_start  (s_axis_tdata[15:0]),
        .region_length (s_axis_tdata[31:16]),
        .poison_value  (signed'(s_axis_tdata[39:32])),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res)
    );

    // Output register
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_data_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_data_reg.error_code, out_data_reg.is_poisoned};

endmodule

// ===== sim/shadow_memory_poison_checker_core_tb.sv =====
`timescale 1ns / 1ps

module shadow_memory_poison_checker_core_tb;

    localparam int GRAN_SHIFT     = 3;
    localparam int GRAN_MASK      = (1 << GRAN_SHIFT) - 1;
    localparam int SHADOW_DEPTH   = 1 << (smcp_pkg::ADDR_W - GRAN_SHIFT);
    localparam int ADDR_SPACE     = 1 << smcp_pkg::ADDR_W;
    localparam int ITEMS_PER_PASS = 367;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int DRAIN_CYCLES   = 20;

    // Mirror of the shadow store plus the queue of verdicts still owed
    class shadow_scoreboard;
        byte                 shadow [SHADOW_DEPTH];
        smcp_pkg::smcp_res_t expected_verdicts [$];
        int                  n_checks;
        int                  n_flagged;
        int                  n_poison;
        int                  n_unpoison;
        int                  n_rejected;
        int                  failures;

        function new();
            foreach (shadow[i])
                shadow[i] = 0;
            n_checks   = 0;
            n_flagged  = 0;
            n_poison   = 0;
            n_unpoison = 0;
            n_rejected = 0;
            failures   = 0;
        endfunction

        // Does [start, stop) touch a poisoned byte?
        function bit region_poisoned(int start, int stop);
            int start_up;
            int end_down;
            int k;
            int off;
            int g;
            start_up = (start + GRAN_MASK) & ~GRAN_MASK;
            end_down = stop & ~GRAN_MASK;
            // partial first granule; a region inside one granule ends here
            if (start_up != start)
            begin
                k = shadow[(start >> GRAN_SHIFT) & (SHADOW_DEPTH - 1)];
                if (stop < start_up)
                begin
                    off = stop & GRAN_MASK;
                    return (k != 0) && (off > k);
                end
                if (k != 0)
                    return 1'b1;
            end
            // partial last granule, signed compare against its shadow
            if (end_down != stop)
            begin
                k   = shadow[(stop >> GRAN_SHIFT) & (SHADOW_DEPTH - 1)];
                off = stop & GRAN_MASK;
                if ((k != 0) && (off > k))
                    return 1'b1;
            end
            // whole granules in between
            for (g = start_up >> GRAN_SHIFT; g < (end_down >> GRAN_SHIFT); g++)
                if (shadow[g & (SHADOW_DEPTH - 1)] != 0)
                    return 1'b1;
            return 1'b0;
        endfunction

        // Apply an accepted request to the mirror and queue its verdict
        function void note_request(logic [smcp_pkg::OP_W-1:0] op,
                                   logic [smcp_pkg::ADDR_W-1:0] start16,
                                   logic [smcp_pkg::ADDR_W-1:0] len16,
                                   logic [smcp_pkg::SHADOW_W-1:0] val);
            int                  start;
            int                  len;
            int                  stop;
            int                  start_up;
            int                  g;
            smcp_pkg::smcp_res_t verdict;
            start = start16;
            len   = len16;
            stop  = start + len;
            verdict.is_poisoned = 1'b0;
            verdict.error_code  = smcp_pkg::ERR_OK;
            if ((len != 0) && (op != smcp_pkg::OP_UNUSED))
            begin
                if (stop > ADDR_SPACE)
                    verdict.error_code = smcp_pkg::ERR_PAST_STORE;
                else if (op == smcp_pkg::OP_CHECK)
                begin
                    verdict.is_poisoned = region_poisoned(start, stop);
                    n_checks++;
                    if (verdict.is_poisoned)
                        n_flagged++;
                end
                else if (op == smcp_pkg::OP_POISON)
                begin
                    if ((stop & GRAN_MASK) != 0)
                        verdict.error_code = smcp_pkg::ERR_POISON_END;
                    else
                    begin
                        start_up = (start + GRAN_MASK) & ~GRAN_MASK;
                        if (start_up != start)
                            shadow[(start >> GRAN_SHIFT) & (SHADOW_DEPTH - 1)] =
                                byte'(start & GRAN_MASK);
                        for (g = start_up >> GRAN_SHIFT; g < (stop >> GRAN_SHIFT); g++)
                            shadow[g & (SHADOW_DEPTH - 1)] = val;
                        n_poison++;
                    end
                end
                else
                begin
                    if ((start & GRAN_MASK) != 0)
                        verdict.error_code = smcp_pkg::ERR_UNPOISON_START;
                    else
                    begin
                        for (g = start >> GRAN_SHIFT; g < (stop >> GRAN_SHIFT); g++)
                            shadow[g & (SHADOW_DEPTH - 1)] = 0;
                        // aligned end writes nothing past the region
                        if ((stop & GRAN_MASK) != 0)
                            shadow[(stop >> GRAN_SHIFT) & (SHADOW_DEPTH - 1)] =
                                byte'(stop & GRAN_MASK);
                        n_unpoison++;
                    end
                end
                if (verdict.error_code != smcp_pkg::ERR_OK)
                    n_rejected++;
            end
            expected_verdicts.push_back(verdict);
        endfunction

        // Compare one result word with the oldest verdict owed
        function void check_verdict(logic [7:0] word);
            smcp_pkg::smcp_res_t exp_v;
            if (expected_verdicts.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, word);
                failures++;
                return;
            end
            exp_v = expected_verdicts.pop_front();
            if (word[0] !== exp_v.is_poisoned)
            begin
                $display("%0t: is_poisoned mismatch, expected %0d, actual %0d",
                         $time, exp_v.is_poisoned, word[0]);
                failures++;
            end
            if (word[2:1] !== exp_v.error_code)
            begin
                $display("%0t: error_code mismatch, expected %0d, actual %0d",
                         $time, exp_v.error_code, word[2:1]);
                failures++;
            end
            if (word[7:3] !== 5'd0)
            begin
                $display("%0t: pad bits mismatch, expected 0, actual %h",
                         $time, word[7:3]);
                failures++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // region_start, region_length, poison_value
    logic [1:0]  s_axis_tuser;   // opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;   // is_poisoned, error_code, zero pad

    shadow_scoreboard board;
    int               src_idle_pct;
    int               sink_idle_pct;
    int               idle_cycles;

    shadow_memory_poison_checker_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // Receiver backpressure
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);

    // Note accepted requests, check accepted results
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            board.note_request(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16],
                               s_axis_tdata[39:32]);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_verdict(m_axis_tdata);
    end

    // Watchdog on cycles without any handshake; reset sweep runs well under it
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("shadow_memory_poison_checker_core_tb failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Present one request word and hold it until accepted
    task automatic send_request(input logic [smcp_pkg::OP_W-1:0] op,
                                input logic [15:0] start,
                                input logic [15:0] len, input logic [7:0] val);
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {val, len, start};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    initial
    begin
        int         pass;
        int         r;
        int         sz;
        int         start;
        int         len;
        int         stop;
        logic [1:0] op;
        logic [7:0] val;

        board         = new();
        idle_cycles   = 0;
        src_idle_pct  = 16;
        sink_idle_pct = 45;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= smcp_pkg::OP_CHECK;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty and full regions, each opcode, each rejection
        send_request(smcp_pkg::OP_CHECK,    16'h0000, 16'h0000, 8'h00);
        send_request(smcp_pkg::OP_CHECK,    16'h0000, 16'hFFFF, 8'h00);
        send_request(smcp_pkg::OP_UNUSED,   16'h0040, 16'h0010, 8'hFF);
        send_request(smcp_pkg::OP_POISON,   16'h0010, 16'h0010, 8'hFF);
        send_request(smcp_pkg::OP_CHECK,    16'h0010, 16'h0001, 8'h00);
        send_request(smcp_pkg::OP_POISON,   16'h0020, 16'h0005, 8'hFF);
        send_request(smcp_pkg::OP_UNPOISON, 16'h0013, 16'h0004, 8'h00);
        send_request(smcp_pkg::OP_CHECK,    16'hFFF0, 16'h0020, 8'h00);
        send_request(smcp_pkg::OP_POISON,   16'hFFF3, 16'h0020, 8'h80);
        // unaligned-start poison leaves the start offset in the first granule
        send_request(smcp_pkg::OP_POISON,   16'h0043, 16'h0015, 8'h7F);
        send_request(smcp_pkg::OP_CHECK,    16'h0040, 16'h0003, 8'h00);
        send_request(smcp_pkg::OP_CHECK,    16'h0040, 16'h0004, 8'h00);
        send_request(smcp_pkg::OP_CHECK,    16'h0041, 16'h0002, 8'h00);
        send_request(smcp_pkg::OP_CHECK,    16'h0041, 16'h0003, 8'h00);
        send_request(smcp_pkg::OP_UNPOISON, 16'h0048, 16'h000B, 8'h00);
        send_request(smcp_pkg::OP_CHECK,    16'h0048, 16'h000B, 8'h00);
        send_request(smcp_pkg::OP_CHECK,    16'h0048, 16'h000C, 8'h00);
        send_request(smcp_pkg::OP_UNPOISON, 16'h0010, 16'h0010, 8'h00);
        // top granule, end exactly at the top of the space
        send_request(smcp_pkg::OP_POISON,   16'hFFF8, 16'h0008, 8'h80);
        send_request(smcp_pkg::OP_CHECK,    16'hFFFF, 16'h0001, 8'h00);
        send_request(smcp_pkg::OP_CHECK,    16'hFFFF, 16'hFFFF, 8'h00);
        // whole-store poison and unpoison
        send_request(smcp_pkg::OP_POISON,   16'h0001, 16'hFFFF, 8'hF9);
        send_request(smcp_pkg::OP_CHECK,    16'h0000, 16'hFFFF, 8'h00);
        send_request(smcp_pkg::OP_UNPOISON, 16'h0000, 16'hFFFF, 8'h00);
        send_request(smcp_pkg::OP_CHECK,    16'hFFF8, 16'h0008, 8'h00);

        // Random traffic: three idle profiles
        for (pass = 0; pass < 3; pass++)
        begin
            src_idle_pct  = (pass == 0) ? 16 : (pass == 1) ? 45 : 0;
            sink_idle_pct = (pass == 0) ? 45 : (pass == 1) ? 16 : 0;
            repeat (ITEMS_PER_PASS)
            begin
                r = $urandom_range(99);
                if (r < 40)
                    op = smcp_pkg::OP_CHECK;
                else if (r < 65)
                    op = smcp_pkg::OP_POISON;
                else if (r < 90)
                    op = smcp_pkg::OP_UNPOISON;
                else if (r < 92)
                    op = smcp_pkg::OP_UNUSED;
                else
                    op = 2'($urandom_range(0, 2));

                // mostly a small hot window so checks meet earlier poison
                start = ($urandom_range(99) < 85) ? $urandom_range(0, 1023)
                                                  : $urandom_range(0, 65535);
                sz = $urandom_range(99);
                if (sz < 88)
                    len = $urandom_range(1, 40);
                else if (sz < 98)
                    len = $urandom_range(41, 600);
                else
                begin
                    len   = $urandom_range(4096, 65535);
                    start = $urandom_range(0, ADDR_SPACE - len);
                end

                // well-formed poison: stretch to an aligned end
                if ((op == smcp_pkg::OP_POISON) && ($urandom_range(99) < 85))
                begin
                    stop = (start + len + GRAN_MASK) & ~GRAN_MASK;
                    if (stop > ADDR_SPACE)
                        stop = ADDR_SPACE;
                    len = stop - start;
                    if (len > 65535)
                        len = len - (GRAN_MASK + 1);
                end
                // well-formed unpoison: aligned start
                if ((op == smcp_pkg::OP_UNPOISON) && ($urandom_range(99) < 85))
                    start = start & ~GRAN_MASK;

                // noise: empty or past-store regions
                if (r >= 92)
                begin
                    if ($urandom_range(1) == 1)
                        len = 0;
                    else
                    begin
                        start = $urandom_range(65000, 65535);
                        len   = $urandom_range(ADDR_SPACE + 1 - start, 65535);
                    end
                end

                r = $urandom_range(99);
                if (r < 50)
                    val = 8'($urandom_range(0, 255));
                else if (r < 70)
                    val = 8'($urandom_range(1, GRAN_MASK));
                else if (r < 80)
                    val = 8'h00;
                else
                    val = 8'($urandom_range(128, 255));

                send_request(op, start[15:0], len[15:0], val);
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain; the watchdog bounds this wait
        while (board.expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d checks (%0d flagged), %0d poison and %0d unpoison updates,",
                 board.n_checks, board.n_flagged, board.n_poison, board.n_unpoison);
        $display("%0d rejected requests, over three backpressure profiles",
                 board.n_rejected);
        if (board.failures == 0)
            $display("shadow_memory_poison_checker_core_tb passed");
        else
            $display("shadow_memory_poison_checker_core_tb failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/smcp_pkg.sv
rtl/core/smcp_ram.sv
rtl/core/smcp_req_dec.sv
rtl/core/smcp_engine.sv
rtl/core/shadow_memory_poison_checker_core.sv
sim/shadow_memory_poison_checker_core_tb.sv
